@@ rtl/aafs_pkg.sv @@
// Shared types and constants for the aim-and-fire sequencer.
// Used by aafs_step and aim_and_fire_sequencer_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aafs_pkg;

   // Default width of the elapsed tick counter
   localparam int TICK_BITS_DEFAULT = 16;

   // Configuration register indexes and reset values
   localparam logic [1:0] CSR_WARMUP       = 2'd0;
   localparam logic [1:0] CSR_TURN_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_AIM_TOL      = 2'd2;

   localparam logic [15:0] WARMUP_RESET       = 16'd75;
   localparam logic [15:0] TURN_TIMEOUT_RESET = 16'd50;
   localparam logic [14:0] AIM_TOL_RESET      = 15'd128;

   // Command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // Illuminator command codes
   localparam logic [1:0] LIGHT_NONE = 2'd0;
   localparam logic [1:0] LIGHT_ON   = 2'd1;
   localparam logic [1:0] LIGHT_OFF  = 2'd2;

   // Sequence states, encoded as on the state output
   typedef enum logic [2:0] {
      ST_LIGHTS = 3'd0,
      ST_CAMERA = 3'd1,
      ST_TURN   = 3'd2,
      ST_SPIN   = 3'd3,
      ST_SHOT1  = 3'd4,
      ST_SHOT2  = 3'd5,
      ST_SHOT3  = 3'd6,
      ST_DONE   = 3'd7
   } state_type;

   // Sequence context held between items (elapsed counter kept apart)
   typedef struct packed {
      state_type          cur;
      state_type          end_st;
      logic [2:0]         target;
      logic signed [15:0] angle;
      logic               empty;
   } ctx_type;

   // Configuration register set
   typedef struct packed {
      logic [15:0] warmup;
      logic [15:0] turn_timeout;
      logic [14:0] aim_tol;
   } cfg_type;

   // One input item
   typedef struct packed {
      logic               command;
      logic [2:0]         target_choice;
      logic [2:0]         stop_after;
      logic               manual_light;
      logic               image_ready;
      logic               targets_seen;
      logic               aim_valid;
      logic signed [15:0] aim_angle;
      logic               turn_done;
      logic               shooter_ready;
   } req_type;

   // One result item
   typedef struct packed {
      logic [2:0]         state;
      logic               finished;
      logic               no_targets;
      logic [1:0]         light_cmd;
      logic               start_capture;
      logic               enable_position;
      logic               turning;
      logic signed [15:0] turn_angle;
      logic               stop_motors;
      logic               shooter_start;
      logic               fire;
      logic [2:0]         chosen_target;
   } rsp_type;

endpackage

`default_nettype wire

@@ rtl/aim_and_fire_sequencer_core.sv @@
// Aim-and-fire sequencer top level: handshakes, registers, result stage.
// Depends on aafs_pkg and aafs_step.
//
// Usage:
//   Input items arrive on req_* (valid/stall). A start item (command 0) latches
//   the target selector and stop-after state and enters lights (done if the
//   stop-after state is done); each tick item (command 1) carries camera,
//   drive and shooter status and advances the sequence by one step.
//   Every accepted item yields exactly one result item on rsp_*, registered at
//   the accepting edge, holding the new state and one-tick action pulses.
//   Throughput is one item per cycle: the sequence state and the result
//   register both load at the accepting edge, and req_stall rises only while
//   a result is held under rsp_stall.
//   The csr_* port writes warm-up ticks, turn timeout and aim tolerance at any
//   edge with csr_wr_en high; write it only while the block is idle.
//   Synchronous reset puts the sequence in done with stop-after done, clears
//   the held target, angle, counter and no-targets flag, restores register
//   defaults and drops rsp_valid.
//   While the receiver stalls a held result, it holds steady and no item is taken.
`timescale 1ns / 1ps
`default_nettype none

module aim_and_fire_sequencer_core import aafs_pkg::*; #(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
   input  wire  logic               clock,
   input  wire  logic               reset,
   // request channel
   input  wire  logic               req_valid,
   output logic                     req_stall,
   input  wire  logic               req_command,
   input  wire  logic [2:0]         req_target_choice,
   input  wire  logic [2:0]         req_stop_after,
   input  wire  logic               req_manual_light,
   input  wire  logic               req_image_ready,
   input  wire  logic               req_targets_seen,
   input  wire  logic               req_aim_valid,
   input  wire  logic signed [15:0] req_aim_angle,
   input  wire  logic               req_turn_done,
   input  wire  logic               req_shooter_ready,
   // response channel
   output logic                     rsp_valid,
   input  wire  logic               rsp_stall,
   output logic [2:0]               rsp_state,
   output logic                     rsp_finished,
   output logic                     rsp_no_targets,
   output logic [1:0]               rsp_light_cmd,
   output logic                     rsp_start_capture,
   output logic                     rsp_enable_position,
   output logic                     rsp_turning,
   output logic signed [15:0]       rsp_turn_angle,
   output logic                     rsp_stop_motors,
   output logic                     rsp_shooter_start,
   output logic                     rsp_fire,
   output logic [2:0]               rsp_chosen_target,
   // configuration port
   input  wire  logic               csr_wr_en,
   input  wire  logic [1:0]         csr_index,
   input  wire  logic [15:0]        csr_wdata
);

   ctx_type              ctx_ff;
   ctx_type              ctx_in;
   logic [TICK_BITS-1:0] elapsed_ff;
   logic [TICK_BITS-1:0] elapsed_in;
   cfg_type              cfg_ff;
   req_type              req;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_valid_ff;
   logic                 req_accept;

   // Take an item unless a result is held under stall
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign req = '{
      command:       req_command,
      target_choice: req_target_choice,
      stop_after:    req_stop_after,
      manual_light:  req_manual_light,
      image_ready:   req_image_ready,
      targets_seen:  req_targets_seen,
      aim_valid:     req_aim_valid,
      aim_angle:     req_aim_angle,
      turn_done:     req_turn_done,
      shooter_ready: req_shooter_ready
   };

   aafs_step #(
      .TICK_BITS (TICK_BITS)
   ) u_step (
      .ctx          (ctx_ff),
      .elapsed      (elapsed_ff),
      .cfg          (cfg_ff),
      .req          (req),
      .ctx_next     (ctx_in),
      .elapsed_next (elapsed_in),
      .rsp          (rsp_in)
   );

   // Advance sequence state on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         ctx_ff.cur    <= ST_DONE;
         ctx_ff.end_st <= ST_DONE;
         ctx_ff.target <= '0;
         ctx_ff.angle  <= '0;
         ctx_ff.empty  <= 1'b0;
         elapsed_ff    <= '0;
      end else if (req_accept) begin
         ctx_ff     <= ctx_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warmup       <= WARMUP_RESET;
         cfg_ff.turn_timeout <= TURN_TIMEOUT_RESET;
         cfg_ff.aim_tol      <= AIM_TOL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WARMUP:       cfg_ff.warmup       <= csr_wdata;
            CSR_TURN_TIMEOUT: cfg_ff.turn_timeout <= csr_wdata;
            CSR_AIM_TOL:      cfg_ff.aim_tol      <= csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // Result register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_state           = rsp_ff.state;
   assign rsp_finished        = rsp_ff.finished;
   assign rsp_no_targets      = rsp_ff.no_targets;
   assign rsp_light_cmd       = rsp_ff.light_cmd;
   assign rsp_start_capture   = rsp_ff.start_capture;
   assign rsp_enable_position = rsp_ff.enable_position;
   assign rsp_turning         = rsp_ff.turning;
   assign rsp_turn_angle      = rsp_ff.turn_angle;
   assign rsp_stop_motors     = rsp_ff.stop_motors;
   assign rsp_shooter_start   = rsp_ff.shooter_start;
   assign rsp_fire            = rsp_ff.fire;
   assign rsp_chosen_target   = rsp_ff.chosen_target;

   // Every accepted item shows up as a result on the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted item produced no result");

   // Done flag tracks the state code
   a_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_finished == (rsp_state == ST_DONE)))
      else $error("finished flag disagrees with state");

   // At most one state entry action per result
   a_one_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_start_capture, rsp_enable_position,
                              rsp_shooter_start, rsp_fire}))
      else $error("more than one entry action in a result");

   // Motors stop only at the end of a turn tick
   a_stop_in_turn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stop_motors) |->
         (rsp_turning && (rsp_state == ST_CAMERA || rsp_state == ST_DONE)))
      else $error("stop_motors outside a finished turn");

endmodule

`default_nettype wire

@@ rtl/aafs_step.sv @@
// Next-state and result logic for one sequencer item.
// Depends on aafs_pkg; purely combinational.
`timescale 1ns / 1ps
`default_nettype none

module aafs_step import aafs_pkg::*; #(
   parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
   input  wire  ctx_type              ctx,
   input  wire  logic [TICK_BITS-1:0] elapsed,
   input  wire  cfg_type              cfg,
   input  wire  req_type              req,
   output ctx_type                    ctx_next,
   output logic [TICK_BITS-1:0]       elapsed_next,
   output rsp_type                    rsp
);

   // Compare width covers both the counter and the 16-bit limits
   localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;

   logic [TICK_BITS-1:0] elapsed_inc;
   logic                 warm_over;
   logic                 turn_over;
   logic [16:0]          angle_ext;
   logic [16:0]          angle_mag;
   logic                 aimed;
   logic                 enter;
   state_type            tgt;
   state_type            chk_cur;
   state_type            chk_end;
   state_type            dest;

   // Saturating tick count and limit checks
   assign elapsed_inc = (&elapsed) ? elapsed : elapsed + 1'b1;
   assign warm_over   = CW'(elapsed_inc) > CW'(cfg.warmup);
   assign turn_over   = CW'(elapsed_inc) > CW'(cfg.turn_timeout);

   // Absolute aim error against tolerance
   assign angle_ext = {req.aim_angle[15], req.aim_angle};
   assign angle_mag = angle_ext[16] ? 17'(-angle_ext) : angle_ext;
   assign aimed     = req.aim_valid && (angle_mag < {2'b00, cfg.aim_tol});

   always_comb begin
      ctx_next     = ctx;
      elapsed_next = elapsed;
      rsp          = '0;
      enter        = 1'b0;
      tgt          = ST_DONE;
      chk_cur      = ctx.cur;
      chk_end      = ctx.end_st;
      dest         = ST_DONE;

      // Pick the transition for this item
      if (req.command == CMD_START) begin
         ctx_next.target = req.target_choice;
         ctx_next.end_st = state_type'(req.stop_after);
         ctx_next.empty  = 1'b0;
         chk_cur         = ST_DONE;
         chk_end         = state_type'(req.stop_after);
         enter           = 1'b1;
         tgt             = ST_LIGHTS;
      end else begin
         elapsed_next = elapsed_inc;
         unique case (ctx.cur)
            ST_LIGHTS: begin
               if (warm_over) begin
                  enter = 1'b1;
                  tgt   = ST_CAMERA;
               end
            end
            ST_CAMERA: begin
               if (req.image_ready) begin
                  if (req.targets_seen) begin
                     ctx_next.angle = req.aim_angle;
                     enter          = 1'b1;
                     tgt            = aimed ? ST_SPIN : ST_TURN;
                  end else begin
                     // nothing seen: straight to done, counter not cleared
                     ctx_next.cur   = ST_DONE;
                     ctx_next.empty = 1'b1;
                  end
               end
            end
            ST_TURN: begin
               rsp.turning = 1'b1;
               if (req.turn_done || turn_over) begin
                  rsp.stop_motors = 1'b1;
                  enter           = 1'b1;
                  tgt             = ST_CAMERA;
               end
            end
            ST_SPIN, ST_SHOT1, ST_SHOT2, ST_SHOT3: begin
               if (req.shooter_ready) begin
                  enter = 1'b1;
                  tgt   = (ctx.cur == ST_SHOT3) ? ST_DONE : state_type'(ctx.cur + 3'd1);
               end
            end
            ST_DONE: begin
            end
         endcase
      end

      // Enter the chosen state, diverting to done past the stop-after state
      if (enter) begin
         dest = (chk_cur == chk_end) ? ST_DONE : tgt;
         unique case (dest)
            ST_LIGHTS: rsp.light_cmd       = LIGHT_ON;
            ST_CAMERA: rsp.start_capture   = 1'b1;
            ST_TURN:   rsp.enable_position = 1'b1;
            ST_SPIN: begin
               rsp.light_cmd     = req.manual_light ? LIGHT_ON : LIGHT_OFF;
               rsp.shooter_start = 1'b1;
            end
            ST_SHOT1, ST_SHOT2, ST_SHOT3: rsp.fire = 1'b1;
            ST_DONE: begin
            end
         endcase
         ctx_next.cur = dest;
         elapsed_next = '0;
      end

      // Held values seen on the result
      rsp.state         = ctx_next.cur;
      rsp.finished      = (ctx_next.cur == ST_DONE);
      rsp.no_targets    = ctx_next.empty;
      rsp.turn_angle    = ctx_next.angle;
      rsp.chosen_target = ctx_next.target;
   end

endmodule

`default_nettype wire
